/* src/dro_pkg.sv */
// Shared types, constants and arctangent table for the odometry block.
package dro_pkg;

  localparam int unsigned CordicStepsDef = 16;
  localparam logic [31:0] TimeoutRst = 32'd600000;
  localparam logic [31:0] CordicX0 = 32'h26DD3B6A;
  localparam logic [31:0] HeadingK = 32'd1467945252;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CORD1_GO,
    ST_CORD1_WAIT,
    ST_MULX,
    ST_MULY,
    ST_MULW,
    ST_CORD2_GO,
    ST_CORD2_WAIT,
    ST_OUT
  } dro_state_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

/* src/dro_cordic.sv */
// Iterative rotation-mode CORDIC: one micro-rotation per cycle.
module dro_cordic #(
  parameter int unsigned CORDIC_STEPS = dro_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [33:0] cos_q,
  output logic signed [33:0] sin_q
);
  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic               flip_r, flip_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [31:0]        ang_rot;
  logic signed [33:0] xs, ys, at;
  logic [4:0]         sh;

  assign sh = 5'(cnt_r);
  assign xs = x_r >>> sh;
  assign ys = y_r >>> sh;
  assign at = 34'(signed'({2'b00, dro_pkg::atan_lut(sh)}));

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    flip_nxt = flip_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ang_rot = angle;
    if (start) begin
      flip_nxt = (angle - 32'h40000000) < 32'h80000000;
      if (flip_nxt) ang_rot = angle - 32'h80000000;
      x_nxt = 34'(signed'({2'b00, dro_pkg::CordicX0}));
      y_nxt = '0;
      z_nxt = 34'(signed'(ang_rot));
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!z_r[33]) begin
        x_nxt = x_r - ys; y_nxt = y_r + xs; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys; y_nxt = y_r - xs; z_nxt = z_r + at;
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CntW'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    flip_r <= flip_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign cos_q = flip_r ? -x_r : x_r;
  assign sin_q = flip_r ? -y_r : y_r;
endmodule

/* src/dead_reckoning_odometry.sv */
// Top level of the dead-reckoning odometry block.
// Usage:
//   The in_ channel takes one telemetry word (stamp, speed, turn rate); the
//   out_ channel returns one pose word per input word. The cfg_ channel
//   writes the feedback timeout; write it only while the block is idle.
//   A word with an accepted gap runs the shared iterative CORDIC twice
//   (doubled old heading, then new heading) and the 64x32 multiplies, each
//   done in two 32-bit halves; a word that skips integration runs the
//   CORDIC once, on the unchanged heading.
//   in_ready is high only while the sequencer is idle; the next word is taken
//   once the pose has been placed in the output register, so a waiting pose
//   and a new word in progress overlap.
//   Reset clears position, heading, the stamp-seen flag and output valid, and
//   loads the timeout with 600000 us. While the receiver stalls, the pose
//   holds in the output register and the block stops after one more word.
module dead_reckoning_odometry #(
  parameter int unsigned CORDIC_STEPS = dro_pkg::CordicStepsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [47:0]        in_stamp_us,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_turn_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_pos_x_nm,
  output logic signed [63:0] out_pos_y_nm,
  output logic [31:0]        out_heading_angle,
  output logic signed [15:0] out_quat_z,
  output logic signed [15:0] out_quat_w,
  output logic               out_integrated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  dro_pkg::dro_state_t state_r, state_nxt;

  logic [31:0] timeout_r;
  logic [63:0] pos_x_r, pos_y_r;
  logic [31:0] heading_r;
  logic [47:0] prev_r, dt_r;
  logic        seen_r;
  logic [15:0] vmag_r, wmag_r;
  logic        vneg_r, wneg_r, adv_r, half_r;
  logic [63:0] vdt_r, wdt_r;
  logic [95:0] acc_r;
  logic        ov_r, ov_nxt;

  logic               cs_start, cs_done;
  logic [31:0]        cs_angle;
  logic signed [33:0] cs_cos, cs_sin;

  logic signed [63:0] ox_r, oy_r;
  logic [31:0]        oh_r;
  logic signed [15:0] oz_r, ow_r;
  logic               oi_r;

  dro_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cs_start), .angle(cs_angle),
    .done(cs_done), .cos_q(cs_cos), .sin_q(cs_sin)
  );

  logic        in_fire, ok_gap;
  logic signed [33:0] trig;
  logic [31:0] mcand;
  logic [63:0] mplier;
  logic [31:0] mhalf;
  logic [63:0] prod;
  logic [95:0] full;
  logic [63:0] rmag;
  logic        rneg;
  logic [31:0] tmag;

  assign in_ready = (state_r == dro_pkg::ST_IDLE);
  assign in_fire = in_valid && in_ready;
  assign cfg_ready = (state_r == dro_pkg::ST_IDLE);
  assign ok_gap = seen_r && (in_stamp_us > prev_r) &&
                  ({1'b0, in_stamp_us - prev_r} < {16'd0, timeout_r, 1'b0});
  assign cs_start = (state_r == dro_pkg::ST_CORD1_GO) || (state_r == dro_pkg::ST_CORD2_GO);
  assign cs_angle = (state_r == dro_pkg::ST_CORD1_GO) ? {heading_r[30:0], 1'b0} : heading_r;

  // Shared 32x32 multiplier: low half then high half of a 64-bit operand.
  assign trig = (state_r == dro_pkg::ST_MULX) ? cs_cos : cs_sin;
  assign tmag = 32'(trig[33] ? -trig : trig);
  always_comb begin
    mcand = (state_r == dro_pkg::ST_MULW) ? dro_pkg::HeadingK : tmag;
    mplier = (state_r == dro_pkg::ST_MULW) ? wdt_r : vdt_r;
    mhalf = half_r ? mplier[63:32] : mplier[31:0];
  end
  assign prod = {32'd0, mhalf} * {32'd0, mcand};
  assign full = acc_r + {prod, 32'd0};
  always_comb begin
    if (state_r == dro_pkg::ST_MULW) rmag = 64'({32'd0, full[95:32]} + 64'(full[31]));
    else rmag = 64'(full[95:30]) + 64'(full[29]);
    case (state_r)
      dro_pkg::ST_MULX: rneg = vneg_r ^ cs_cos[33];
      dro_pkg::ST_MULY: rneg = vneg_r ^ cs_sin[33];
      default: rneg = wneg_r;
    endcase
  end

  function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
    logic signed [34:0] t;
    logic signed [19:0] r;
    t = 35'(v) + 35'sd16384;
    r = 20'(t >>> 15);
    if (r > 20'sd32767) return 16'sh7FFF;
    if (r < -20'sd32768) return 16'sh8000;
    return 16'(r);
  endfunction

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dro_pkg::ST_IDLE: if (in_fire) state_nxt = dro_pkg::ST_CHECK;
      dro_pkg::ST_CHECK: state_nxt = adv_r ? dro_pkg::ST_CORD1_GO : dro_pkg::ST_CORD2_GO;
      dro_pkg::ST_CORD1_GO: state_nxt = dro_pkg::ST_CORD1_WAIT;
      dro_pkg::ST_CORD1_WAIT: if (cs_done) state_nxt = dro_pkg::ST_MULX;
      dro_pkg::ST_MULX: if (half_r) state_nxt = dro_pkg::ST_MULY;
      dro_pkg::ST_MULY: if (half_r) state_nxt = dro_pkg::ST_MULW;
      dro_pkg::ST_MULW: if (half_r) state_nxt = dro_pkg::ST_CORD2_GO;
      dro_pkg::ST_CORD2_GO: state_nxt = dro_pkg::ST_CORD2_WAIT;
      dro_pkg::ST_CORD2_WAIT: if (cs_done) state_nxt = dro_pkg::ST_OUT;
      dro_pkg::ST_OUT: if (!ov_r || out_ready) state_nxt = dro_pkg::ST_IDLE;
      default: state_nxt = dro_pkg::ST_IDLE;
    endcase
  end

  // Drop valid when the word is taken, raise it when a new pose is loaded
  always_comb begin
    ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if ((state_r == dro_pkg::ST_OUT) && (!ov_r || out_ready)) ov_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dro_pkg::ST_IDLE;
      timeout_r <= dro_pkg::TimeoutRst;
      pos_x_r <= '0;
      pos_y_r <= '0;
      heading_r <= '0;
      prev_r <= '0;
      seen_r <= 1'b0;
      ov_r <= 1'b0;
      half_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      if (cfg_valid && cfg_ready) timeout_r <= cfg_data;
      case (state_r)
        dro_pkg::ST_IDLE: if (in_fire) begin
          adv_r <= ok_gap;
          dt_r <= in_stamp_us - prev_r;
          prev_r <= in_stamp_us;
          seen_r <= 1'b1;
          vneg_r <= in_linear_speed[15];
          wneg_r <= in_turn_rate[15];
          vmag_r <= in_linear_speed[15] ? -in_linear_speed : in_linear_speed;
          wmag_r <= in_turn_rate[15] ? -in_turn_rate : in_turn_rate;
        end
        dro_pkg::ST_CHECK: begin
          // dt fits in 33 bits when accepted, so 16x48 products fit in 64
          vdt_r <= 64'({48'd0, vmag_r} * {16'd0, dt_r});
          wdt_r <= 64'({48'd0, wmag_r} * {16'd0, dt_r});
          acc_r <= '0;
          half_r <= 1'b0;
        end
        dro_pkg::ST_MULX, dro_pkg::ST_MULY, dro_pkg::ST_MULW: begin
          if (!half_r) begin
            acc_r <= {32'd0, prod};
            half_r <= 1'b1;
          end else begin
            acc_r <= '0;
            half_r <= 1'b0;
            // high half is shifted 32 left
            case (state_r)
              dro_pkg::ST_MULX: pos_x_r <= pos_x_r + (rneg ? -rmag : rmag);
              dro_pkg::ST_MULY: pos_y_r <= pos_y_r + (rneg ? -rmag : rmag);
              default: heading_r <= heading_r + (rneg ? -rmag[31:0] : rmag[31:0]);
            endcase
          end
        end
        dro_pkg::ST_OUT: if (!ov_r || out_ready) begin
          ox_r <= pos_x_r;
          oy_r <= pos_y_r;
          oh_r <= heading_r;
          oz_r <= to_q15(cs_sin);
          ow_r <= to_q15(cs_cos);
          oi_r <= adv_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_pos_x_nm = ox_r;
  assign out_pos_y_nm = oy_r;
  assign out_heading_angle = oh_r;
  assign out_quat_z = oz_r;
  assign out_quat_w = ow_r;
  assign out_integrated = oi_r;
endmodule

/* tb/dro_checker.sv */
// Pose predictor and result checker for the odometry block.
module dro_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [47:0]        in_stamp_us,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_turn_rate,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [63:0] out_pos_x_nm,
  input  logic signed [63:0] out_pos_y_nm,
  input  logic [31:0]        out_heading_angle,
  input  logic signed [15:0] out_quat_z,
  input  logic signed [15:0] out_quat_w,
  input  logic               out_integrated,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  output int                 fails,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RotSteps = 16;
  localparam logic [31:0] ArcTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic [31:0] hd;
    logic [15:0] qz;
    logic [15:0] qw;
    logic        adv;
  } pose_t;

  pose_t       pose_q[$];
  logic [31:0] timeout_us;
  logic [63:0] cur_x, cur_y;
  logic [31:0] cur_hd;
  logic [47:0] last_stamp;
  logic        have_stamp;

  assign pending = pose_q.size();

  // Rotation-mode CORDIC, results in Q2.30
  function automatic void rotate(input logic [31:0] ang, output longint c, output longint s);
    logic [31:0] t, a;
    logic        flip;
    longint      x, y, z, xs, ys;
    t = ang - 32'h40000000;
    flip = ~t[31];
    a = flip ? ang - 32'h80000000 : ang;
    z = longint'(signed'(a));
    x = longint'(dro_pkg::CordicX0);
    y = 0;
    for (int i = 0; i < RotSteps; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(ArcTab[i]);
      end else begin
        x += ys; y -= xs; z += longint'(ArcTab[i]);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [63:0] scale_round(input logic [63:0] a, input logic [63:0] k,
                                              input int sh);
    logic [63:0] hi, lo;
    hi = a >> sh;
    lo = a & ((64'd1 << sh) - 64'd1);
    return hi * k + ((lo * k + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic logic [63:0] magn(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [15:0] to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic pose_t advance_pose(input logic [47:0] stamp, input longint v,
                                         input longint w);
    pose_t       p;
    logic [63:0] dt, vdt, wdt, step;
    longint      c, s;
    p.adv = 1'b0;
    if (have_stamp && stamp > last_stamp) begin
      dt = stamp - last_stamp;
      if (dt < 64'd2 * {32'd0, timeout_us}) begin
        vdt = magn(v) * dt;
        wdt = magn(w) * dt;
        rotate(cur_hd << 1, c, s);
        step = scale_round(vdt, magn(c), 30);
        cur_x += ((v < 0) != (c < 0)) ? -step : step;
        step = scale_round(vdt, magn(s), 30);
        cur_y += ((v < 0) != (s < 0)) ? -step : step;
        step = scale_round(wdt, {32'd0, dro_pkg::HeadingK}, 32);
        cur_hd += (w < 0) ? -step[31:0] : step[31:0];
        p.adv = 1'b1;
      end
    end
    last_stamp = stamp;
    have_stamp = 1'b1;
    rotate(cur_hd, c, s);
    p.x = cur_x;
    p.y = cur_y;
    p.hd = cur_hd;
    p.qz = to_q15(s);
    p.qw = to_q15(c);
    return p;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    fails++;
  endtask

  always @(posedge clk) begin
    pose_t w;
    if (!rst_n) begin
      fails = 0;
      timeout_us = dro_pkg::TimeoutRst;
      cur_x = '0; cur_y = '0; cur_hd = '0;
      last_stamp = '0; have_stamp = 1'b0;
      pose_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) timeout_us = cfg_data;
      if (in_valid && in_ready)
        pose_q.insert(pose_q.size(), advance_pose(in_stamp_us, longint'(in_linear_speed),
                                                  longint'(in_turn_rate)));
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          report("unexpected word", out_pos_x_nm, 64'd0);
        end else begin
          w = pose_q.pop_front();
          if (out_pos_x_nm !== w.x) report("pos_x_nm", out_pos_x_nm, w.x);
          if (out_pos_y_nm !== w.y) report("pos_y_nm", out_pos_y_nm, w.y);
          if (out_heading_angle !== w.hd) report("heading_angle", out_heading_angle, w.hd);
          if (out_quat_z !== w.qz) report("quat_z", out_quat_z, w.qz);
          if (out_quat_w !== w.qw) report("quat_w", out_quat_w, w.qw);
          if (out_integrated !== w.adv) report("integrated", out_integrated, w.adv);
        end
      end
    end
  end

endmodule

/* tb/dead_reckoning_odometry_test.sv */
// Stimulus, clocking and verdict for the odometry block test.
module dead_reckoning_odometry_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 80;
  localparam int StallLimit = 4000;

  logic               clk, rst_n;
  logic               in_valid, in_ready;
  logic [47:0]        in_stamp_us;
  logic signed [15:0] in_linear_speed, in_turn_rate;
  logic               out_valid, out_ready;
  logic signed [63:0] out_pos_x_nm, out_pos_y_nm;
  logic [31:0]        out_heading_angle;
  logic signed [15:0] out_quat_z, out_quat_w;
  logic               out_integrated;
  logic               cfg_valid, cfg_ready;
  logic [31:0]        cfg_data;
  int                 fails, pending;

  logic [31:0] timeout_now;
  logic [47:0] stamp_now;
  logic        calm;
  int          hold;
  int          quiet;

  dead_reckoning_odometry dut (.*);

  dro_checker chk (.*);

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_stamp_us = '0;
    in_linear_speed = '0;
    in_turn_rate = '0;
    out_ready = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    hold = 0;
    quiet = 0;
  end

  always #4 clk = ~clk;

  // Receiver: stall a random number of cycles after each word
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      hold = calm ? 0 : $urandom_range(0, 5);
      out_ready <= (hold == 0);
    end else if (hold > 0) begin
      hold--;
      out_ready <= (hold == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) ||
        !rst_n)
      quiet = 0;
    else
      quiet++;
    if (quiet >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic [47:0] stamp, input logic [15:0] v,
                           input logic [15:0] w);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_stamp_us <= stamp;
    in_linear_speed <= v;
    in_turn_rate <= w;
    stamp_now = stamp;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drain, let the block settle, then load a new timeout
  task automatic set_timeout(input logic [31:0] t);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= t;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    timeout_now = t;
  endtask

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'(signed'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] next_stamp();
    logic [63:0] lim, dt;
    lim = 64'd2 * {32'd0, timeout_now};
    case ($urandom_range(0, 15))
      0: dt = lim;
      1: dt = (lim > 0) ? lim - 1 : 0;
      2: dt = 0;
      3: return 48'({$urandom, $urandom});
      4: dt = lim + $urandom_range(1, 1000);
      5, 6: dt = $urandom_range(1, 100);
      default: dt = (lim > 1) ? 1 + ({$urandom, $urandom} % (lim - 1)) : 1;
    endcase
    return stamp_now + 48'(dt);
  endfunction

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++)
      send_word(next_stamp(), pick_rate(), pick_rate());
  endtask

  initial begin
    timeout_now = 32'd600000;
    stamp_now = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: first word, extremes, equal and earlier stamps, gap edges
    send_word(48'd0, 16'h7FFF, 16'h7FFF);
    send_word(48'd1000, 16'h7FFF, 16'h7FFF);
    send_word(48'd1000, 16'h7FFF, 16'h7FFF);
    send_word(48'd500, 16'h8000, 16'h8000);
    send_word(48'd1500, 16'h8000, 16'h8000);
    send_word(48'd1500 + 48'd1199999, 16'h1234, 16'hEDCB);
    send_word(48'd1500 + 48'd2399999, 16'h7FFF, 16'h0001);
    send_word(48'd1500 + 48'd2400000, 16'h0000, 16'h0000);
    send_word(48'hFFFF_FFFF_FFFF, 16'h0001, 16'hFFFF);
    send_word(48'd0, 16'h0001, 16'hFFFF);
    set_timeout(32'd1);
    send_word(48'd1, 16'h7FFF, 16'h7FFF);
    send_word(48'd3, 16'h7FFF, 16'h7FFF);
    set_timeout(32'd0);
    send_word(48'd4, 16'h7FFF, 16'h7FFF);
    send_word(48'd5, 16'h7FFF, 16'h7FFF);
    set_timeout(32'hFFFF_FFFF);
    send_word(48'h1_FFFF_FFFF, 16'h7FFF, 16'h7FFF);
    send_word(48'h3_FFFF_FFFC, 16'h8000, 16'h7FFF);
    send_word(48'h5_FFFF_FFFA, 16'h7FFF, 16'h8000);
    send_word(48'h7_FFFF_FFF9, 16'h8000, 16'h8000);

    // Random phases across several timeouts
    random_run(200);
    set_timeout(32'd600000);
    random_run(200);
    calm = 1'b1;
    random_run(100);
    calm = 1'b0;
    set_timeout($urandom_range(1, 5000));
    random_run(150);
    set_timeout(32'd1);
    random_run(50);
    set_timeout($urandom);
    random_run(150);
    set_timeout(32'd0);
    random_run(30);

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fails == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
